FILE: design/kswr_pkg.sv
// Shared types and constants for the keyed sample-without-replacement core.
// Holds the AES S-box and xtime functions, status codes, register indices,
// the AES control struct and the controller state type. No dependencies.
package kswr_pkg;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_CFG = 2'd2;

  localparam logic [1:0] REG_KEY_LOW = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_POP_SIZE = 2'd2;
  localparam logic [1:0] REG_SAMPLE_CNT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CHECK,
    S_AES_START,
    S_AES_WAIT,
    S_READ,
    S_WAIT_RD,
    S_MARK,
    S_OUT
  } ctl_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } aes_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [0:255];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

FILE: design/keyed_sample_without_replacement_core.sv
// Keyed sample-without-replacement core: Floyd sampling driven by AES-128.
// Top level; depends on kswr_pkg and kswr_aes.
//
// Each item on the in_ channel asks for one index; in_begin_run set starts a
// new run. Every item yields exactly one result on the out_ channel with the
// index, a last flag and a status code. The user must write configuration
// registers through the cfg_ channel only while the core is idle; the core
// does not enforce this. The core handles one item at a time. Each draw runs
// one or more AES attempts (ten rounds in the round-iterative AES unit plus
// load and hand-off), on average at most two. An ok item passes the check,
// AES start and wait, bitmap read, read wait and mark states before out_valid
// is raised, and a rejected candidate starts a new AES attempt. A bad or
// exhausted item goes to the output state without a draw.
// A run start clears the membership bitmap one word per cycle; the bitmap is
// a memory with a registered read, and the same sweep runs once after reset
// while no item is accepted.
// Reset empties the output register and zeroes the counters. While out_stall
// is high the result holds and no new item is taken.
module keyed_sample_without_replacement_core import kswr_pkg::*; #(
  parameter int MAX_POPULATION = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_begin_run,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_sample_index,
  output logic        out_is_last,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int WORDS = (MAX_POPULATION + 31) / 32;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  ctl_state_t   state_r, state_nxt;
  logic [63:0]  key_low_r, key_high_r;
  logic [16:0]  pop_r, cnt_r;
  logic [16:0]  bound_r, bound_nxt;
  logic [16:0]  prod_r, prod_nxt;
  logic [31:0]  ctr_r, ctr_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic         init_r, init_nxt;
  logic         begin_r, begin_nxt;
  logic [16:0]  val_r, val_nxt;
  logic [31:0]  word_r;
  logic [15:0]  idx_r, idx_nxt;
  logic         last_r, last_nxt;
  logic [1:0]   stat_r, stat_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [31:0]  mem [0:WORDS-1];
  logic         mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]  mem_wd;
  aes_ctl_t     aes_ctl;
  logic         aes_done;
  logic [127:0] aes_ct;
  logic [16:0]  mask;
  logic [16:0]  cand;
  logic [16:0]  pick;
  logic         bad_cfg, exhausted;

  kswr_aes u_aes (
    .clk(clk), .rst_n(rst_n), .ctl_in(aes_ctl),
    .key({key_high_r, key_low_r}), .pt({96'd0, ctr_r}),
    .done(aes_done), .ct(aes_ct)
  );

  // Mask 2P-1 with P the largest power of two not above bound+1.
  always_comb begin
    logic [16:0] l;
    l = bound_r + 17'd1;
    mask = l;
    for (int s = 1; s < 17; s = s * 2) begin
      mask = mask | (mask >> s);
    end
  end

  assign cand = aes_ct[16:0] & mask;
  assign bad_cfg = (pop_r == 17'd0) || (32'(pop_r) > 32'(MAX_POPULATION)) || (cnt_r > pop_r);
  assign exhausted = (prod_r >= cnt_r) || (bound_r >= pop_r);
  assign pick = word_r[val_r[4:0]] ? bound_r : val_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!init_r) begin
        state_nxt = S_CLEAR;
      end else if (in_valid) begin
        state_nxt = S_CHECK;
      end
      S_CLEAR: if (32'(clr_r) == WORDS - 1) begin
        state_nxt = init_r ? S_AES_START : S_IDLE;
      end
      S_CHECK: begin
        if (bad_cfg) begin
          state_nxt = S_OUT;
        end else if (begin_r) begin
          state_nxt = S_CLEAR;
        end else if (exhausted) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_AES_START;
        end
      end
      S_AES_START: state_nxt = exhausted ? S_OUT : S_AES_WAIT;
      S_AES_WAIT: if (aes_done) begin
        state_nxt = (cand < bound_r + 17'd1) ? S_READ : S_AES_START;
      end
      S_READ: state_nxt = S_WAIT_RD;
      S_WAIT_RD: state_nxt = S_MARK;
      S_MARK: state_nxt = S_OUT;
      S_OUT: if (!out_stall || !ovalid_r) begin
        state_nxt = ovalid_r ? S_IDLE : S_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    bound_nxt = bound_r;
    prod_nxt = prod_r;
    ctr_nxt = ctr_r;
    clr_nxt = clr_r;
    init_nxt = init_r;
    begin_nxt = begin_r;
    val_nxt = val_r;
    idx_nxt = idx_r;
    last_nxt = last_r;
    stat_nxt = stat_r;
    ovalid_nxt = ovalid_r;
    aes_ctl = '0;
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wd = '0;
    mem_ra = AW'(val_r[16:5]);
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        begin_nxt = in_begin_run;
        clr_nxt = '0;
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (32'(clr_r) == WORDS - 1) begin
          init_nxt = 1'b1;
          if (init_r) begin
            ctr_nxt = '0;
            prod_nxt = '0;
            bound_nxt = pop_r - cnt_r;
          end
        end
      end
      S_CHECK: begin
        idx_nxt = '0;
        last_nxt = 1'b0;
        stat_nxt = bad_cfg ? ST_BAD_CFG : ST_EXHAUSTED;
      end
      S_AES_START: begin
        idx_nxt = '0;
        last_nxt = 1'b0;
        stat_nxt = ST_EXHAUSTED;
        aes_ctl.start = !exhausted;
      end
      S_AES_WAIT: if (aes_done) begin
        ctr_nxt = ctr_r + 32'd1;
        val_nxt = cand;
      end
      S_WAIT_RD: begin
        val_nxt = pick;
        mem_ra = AW'(pick[16:5]);
      end
      S_MARK: begin
        mem_we = 1'b1;
        mem_wa = AW'(val_r[16:5]);
        mem_wd = word_r | (32'd1 << val_r[4:0]);
        bound_nxt = bound_r + 17'd1;
        prod_nxt = prod_r + 17'd1;
        idx_nxt = val_r[15:0];
        last_nxt = (prod_r + 17'd1) == cnt_r;
        stat_nxt = ST_OK;
      end
      S_OUT: if (!ovalid_r) begin
        ovalid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    word_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      key_low_r <= '0;
      key_high_r <= '0;
      pop_r <= '0;
      cnt_r <= '0;
      bound_r <= '0;
      prod_r <= '0;
      ctr_r <= '0;
      clr_r <= '0;
      init_r <= 1'b0;
      begin_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bound_r <= bound_nxt;
      prod_r <= prod_nxt;
      ctr_r <= ctr_nxt;
      clr_r <= clr_nxt;
      init_r <= init_nxt;
      begin_r <= begin_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_LOW: key_low_r <= cfg_data;
          REG_KEY_HIGH: key_high_r <= cfg_data;
          REG_POP_SIZE: pop_r <= cfg_data[16:0];
          REG_SAMPLE_CNT: cnt_r <= cfg_data[16:0];
          default: ;
        endcase
      end
    end
    val_r <= val_nxt;
    idx_r <= idx_nxt;
    last_r <= last_nxt;
    stat_r <= stat_nxt;
  end

  assign in_stall = (state_r != S_IDLE) || !init_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_sample_index = idx_r;
  assign out_is_last = last_r;
  assign out_status = stat_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_CHECK)
    else $error("accepted item did not start a check");
  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> 32'(out_sample_index) < 32'(pop_r))
    else $error("index outside population");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

endmodule

FILE: design/kswr_aes.sv
// Round-iterative AES-128 encryptor, one round per cycle with the key schedule
// computed alongside. Depends on kswr_pkg.
module kswr_aes import kswr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  aes_ctl_t     ctl_in,
  input  logic [127:0] key,
  input  logic [127:0] pt,
  output logic         done,
  output logic [127:0] ct
);

  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [3:0]   round_r, round_nxt;
  logic         busy_r, busy_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic         done_r, done_nxt;
  logic [127:0] sub;
  logic [127:0] mix;

  // Byte k of the state and round key lives in bits 8k+7..8k.
  always_comb begin
    logic [7:0] a0, a1, a2, a3, t;
    logic [31:0] w3;
    logic [7:0] rc;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        sub[(c*4+k)*8 +: 8] = sbox(st_r[(((c+k)%4)*4+k)*8 +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sub[(c*4)*8 +: 8];
      a1 = sub[(c*4+1)*8 +: 8];
      a2 = sub[(c*4+2)*8 +: 8];
      a3 = sub[(c*4+3)*8 +: 8];
      t = a0 ^ a1 ^ a2 ^ a3;
      mix[(c*4)*8 +: 8]   = a0 ^ t ^ xtime(a0 ^ a1);
      mix[(c*4+1)*8 +: 8] = a1 ^ t ^ xtime(a1 ^ a2);
      mix[(c*4+2)*8 +: 8] = a2 ^ t ^ xtime(a2 ^ a3);
      mix[(c*4+3)*8 +: 8] = a3 ^ t ^ xtime(a3 ^ a0);
    end
    w3 = rk_r[127:96];
    rc = rcon_r;
    rk_nxt[7:0]   = rk_r[7:0]   ^ sbox(w3[15:8]) ^ rc;
    rk_nxt[15:8]  = rk_r[15:8]  ^ sbox(w3[23:16]);
    rk_nxt[23:16] = rk_r[23:16] ^ sbox(w3[31:24]);
    rk_nxt[31:24] = rk_r[31:24] ^ sbox(w3[7:0]);
    rk_nxt[63:32]  = rk_r[63:32]  ^ rk_nxt[31:0];
    rk_nxt[95:64]  = rk_r[95:64]  ^ rk_nxt[63:32];
    rk_nxt[127:96] = rk_r[127:96] ^ rk_nxt[95:64];
  end

  always_comb begin
    st_nxt = st_r;
    round_nxt = round_r;
    busy_nxt = busy_r;
    rcon_nxt = rcon_r;
    done_nxt = 1'b0;
    if (ctl_in.start) begin
      st_nxt = pt ^ key;
      round_nxt = 4'd1;
      busy_nxt = 1'b1;
      rcon_nxt = 8'h01;
    end else if (busy_r) begin
      st_nxt = ((round_r == 4'd10) ? sub : mix) ^ rk_nxt;
      round_nxt = round_r + 4'd1;
      rcon_nxt = xtime(rcon_r);
      if (round_r == 4'd10) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      round_r <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      round_r <= round_nxt;
    end
    st_r <= st_nxt;
    rcon_r <= rcon_nxt;
    if (ctl_in.start) begin
      rk_r <= key;
    end else if (busy_r) begin
      rk_r <= rk_nxt;
    end
  end

  assign done = done_r;
  assign ct = st_r;

endmodule

FILE: verif/tb_keyed_sample_without_replacement_core.sv
// Testbench for keyed_sample_without_replacement_core: drives index requests
// and register writes, predicts each result with a local AES-128 Floyd sampler.
// Depends on kswr_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_keyed_sample_without_replacement_core;
  import kswr_pkg::*;

  localparam int MAX_POP = 65536;
  localparam int BITMAP_WORDS = MAX_POP / 32;

  typedef struct packed {
    logic [15:0] sample_index;
    logic        is_last;
    logic [1:0]  status;
  } sample_t;

  typedef struct {
    logic       begin_run;
    logic       fixed;
    sample_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_begin_run;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_sample_index;
  logic        out_is_last;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  keyed_sample_without_replacement_core #(.MAX_POPULATION(MAX_POP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_begin_run(in_begin_run),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_index(out_sample_index), .out_is_last(out_is_last),
    .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [63:0] key_lo_q, key_hi_q;
  logic [16:0] pop_q, count_q;
  logic [31:0] bitmap_q [BITMAP_WORDS];
  logic [16:0] bound_q, produced_q;
  logic [31:0] ctr_q;

  sample_t expected_samples[$];
  int errors;
  int send_idle_pct, recv_stall_pct;
  bit long_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] aes_word(input logic [31:0] ctr);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] t0, t1, t2, t3, s, a0, a1, a2, a3, tx;
    logic [7:0] rc;
    rc = 8'h01;
    for (int b = 0; b < 16; b++)
      rk[b] = (b < 8) ? key_lo_q[8*b +: 8] : key_hi_q[8*(b-8) +: 8];
    for (int b = 16; b < 176; b += 4) begin
      t0 = rk[b-4]; t1 = rk[b-3]; t2 = rk[b-2]; t3 = rk[b-1];
      if (b % 16 == 0) begin
        s = t0;
        t0 = sbox(t1) ^ rc;
        t1 = sbox(t2);
        t2 = sbox(t3);
        t3 = sbox(s);
        rc = gmul2(rc);
      end
      rk[b] = rk[b-16] ^ t0;
      rk[b+1] = rk[b-15] ^ t1;
      rk[b+2] = rk[b-14] ^ t2;
      rk[b+3] = rk[b-13] ^ t3;
    end
    for (int k = 0; k < 16; k++) st[k] = 8'h00;
    for (int k = 0; k < 4; k++) st[k] = ctr[8*k +: 8];
    for (int k = 0; k < 16; k++) st[k] ^= rk[k];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++)
          tmp[c*4+k] = sbox(st[((c+k)%4)*4+k]);
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[c*4]; a1 = tmp[c*4+1]; a2 = tmp[c*4+2]; a3 = tmp[c*4+3];
          tx = a0 ^ a1 ^ a2 ^ a3;
          tmp[c*4] = a0 ^ tx ^ gmul2(a0 ^ a1);
          tmp[c*4+1] = a1 ^ tx ^ gmul2(a1 ^ a2);
          tmp[c*4+2] = a2 ^ tx ^ gmul2(a2 ^ a3);
          tmp[c*4+3] = a3 ^ tx ^ gmul2(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) st[k] = tmp[k] ^ rk[r*16+k];
    end
    return {st[3], st[2], st[1], st[0]};
  endfunction

  function automatic sample_t predict_sample(input logic begin_run);
    sample_t res;
    logic [31:0] lim, p, mask, v, pick;
    res = '0;
    if (pop_q == 0 || pop_q > MAX_POP || count_q > pop_q) begin
      res.status = ST_BAD_CFG;
      return res;
    end
    if (begin_run) begin
      for (int w = 0; w < BITMAP_WORDS; w++) bitmap_q[w] = '0;
      ctr_q = '0;
      produced_q = '0;
      bound_q = pop_q - count_q;
    end
    if (produced_q >= count_q || bound_q >= pop_q) begin
      res.status = ST_EXHAUSTED;
      return res;
    end
    lim = bound_q + 1;
    p = 1;
    while ((p << 1) <= lim) p = p << 1;
    mask = (p << 1) - 1;
    do begin
      v = aes_word(ctr_q) & mask;
      ctr_q = ctr_q + 1;
    end while (v >= lim);
    pick = bitmap_q[(v >> 5) % BITMAP_WORDS][v[4:0]] ? bound_q : v;
    bitmap_q[(pick >> 5) % BITMAP_WORDS][pick[4:0]] = 1'b1;
    bound_q = bound_q + 17'd1;
    produced_q = produced_q + 17'd1;
    res.sample_index = pick[15:0];
    res.is_last = (produced_q == count_q);
    res.status = ST_OK;
    return res;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KEY_LOW: key_lo_q = data;
      REG_KEY_HIGH: key_hi_q = data;
      REG_POP_SIZE: pop_q = data[16:0];
      default: count_q = data[16:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_run(input logic [16:0] pop, input logic [16:0] cnt);
    write_reg(REG_POP_SIZE, {47'd0, pop});
    write_reg(REG_SAMPLE_CNT, {47'd0, cnt});
  endtask

  // Drains outstanding results, then leaves room for an in-flight bitmap sweep.
  task automatic settle();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (MAX_POP / 32 + 100) @(posedge clk);
  endtask

  task automatic send_request(input logic begin_run, input logic fixed,
                              input sample_t want);
    sample_t pred;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_begin_run <= begin_run;
    do @(posedge clk); while (in_stall);
    pred = predict_sample(begin_run);
    if (fixed && pred != want)
      $display("%0t: table row disagrees with predictor, row %h pred %h",
               $time, want, pred);
    expected_samples.push_back(fixed ? want : pred);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    sample_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_sample_index, out_is_last, out_status};
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample %h", $time, got);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (got.sample_index !== want.sample_index) begin
          $display("%0t: sample_index expected %0d actual %0d", $time,
                   want.sample_index, got.sample_index);
          errors++;
        end
        if (got.is_last !== want.is_last) begin
          $display("%0t: is_last expected %0d actual %0d", $time,
                   want.is_last, got.is_last);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, got.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if (recv_stall_pct > 0) out_stall <= ($urandom_range(99) < recv_stall_pct);
    else out_stall <= 1'b0;
  end

  task automatic run_phase(input int n, input int sidle, input int rstall);
    logic [16:0] pop, cnt;
    int left;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    left = n;
    while (left > 0) begin
      settle();
      if ($urandom_range(9) == 0) write_reg(REG_KEY_LOW, {$urandom, $urandom});
      if ($urandom_range(9) == 0) write_reg(REG_KEY_HIGH, {$urandom, $urandom});
      case ($urandom_range(9))
        0: pop = 17'($urandom_range(65536, 1));
        1: pop = 17'h1ffff - 17'($urandom_range(3));
        default: pop = 17'($urandom_range(200, 1));
      endcase
      cnt = ($urandom_range(15) == 0) ? pop + 17'd1 :
            17'($urandom_range(pop > 40 ? 40 : pop));
      set_run(pop, cnt);
      send_request(1'b1, 1'b0, '0);
      left--;
      for (int k = 0; k < cnt + 2 && left > 0; k++) begin
        send_request($urandom_range(30) == 0, 1'b0, '0);
        left--;
      end
      idle_input();
    end
  endtask

  stim_row_t directed [$];

  initial begin
    sample_t bad, exh;
    bad = '{16'd0, 1'b0, ST_BAD_CFG};
    exh = '{16'd0, 1'b0, ST_EXHAUSTED};
    errors = 0;
    long_hold = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_begin_run = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY_LOW;
    cfg_data = '0;
    key_lo_q = '0; key_hi_q = '0; pop_q = '0; count_q = '0;
    bound_q = '0; produced_q = '0; ctr_q = '0;
    for (int w = 0; w < BITMAP_WORDS; w++) bitmap_q[w] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{'{1'b0, 1'b1, bad}, '{1'b1, 1'b1, bad}};
    foreach (directed[r]) send_request(directed[r].begin_run, directed[r].fixed,
                                       directed[r].want);
    idle_input();
    settle();
    set_run(17'd1, 17'd0);
    directed = '{'{1'b0, 1'b1, exh}, '{1'b1, 1'b1, exh}};
    foreach (directed[r]) send_request(directed[r].begin_run, directed[r].fixed,
                                       directed[r].want);
    idle_input();
    settle();
    set_run(17'd1, 17'd1);
    directed = '{'{1'b1, 1'b1, '{16'd0, 1'b1, ST_OK}}, '{1'b0, 1'b1, exh},
                 '{1'b1, 1'b1, '{16'd0, 1'b1, ST_OK}}};
    foreach (directed[r]) send_request(directed[r].begin_run, directed[r].fixed,
                                       directed[r].want);
    idle_input();
    settle();
    write_reg(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
    set_run(17'd65536, 17'd4);
    directed = '{'{1'b1, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0},
                 '{1'b0, 1'b0, '0}, '{1'b0, 1'b1, exh}};
    foreach (directed[r]) send_request(directed[r].begin_run, directed[r].fixed,
                                       directed[r].want);
    idle_input();
    settle();
    set_run(17'd65537, 17'd1);
    send_request(1'b0, 1'b1, bad);
    idle_input();
    settle();
    set_run(17'd5, 17'd6);
    send_request(1'b1, 1'b1, bad);
    idle_input();
    settle();
    write_reg(REG_KEY_LOW, 64'h0123_4567_89ab_cdef);
    write_reg(REG_KEY_HIGH, 64'h0);
    set_run(17'd40, 17'd40);
    send_request(1'b1, 1'b0, '0);
    for (int k = 0; k < 40; k++) send_request(1'b0, 1'b0, '0);
    idle_input();

    settle();
    set_run(17'd64, 17'd30);
    long_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      begin
        send_request(1'b1, 1'b0, '0);
        for (int k = 0; k < 8; k++) send_request(1'b0, 1'b0, '0);
      end
    join
    idle_input();

    run_phase(500, 0, 0);
    run_phase(450, 84, 0);
    run_phase(450, 0, 84);
    run_phase(450, 38, 38);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
